// File: rtl/core/lox_lexer_token_scanner_unit_defines.svh
// Assertion macros shared by the scanner checker
`ifndef LOX_LEXER_TOKEN_SCANNER_UNIT_DEFINES_SVH
`define LOX_LEXER_TOKEN_SCANNER_UNIT_DEFINES_SVH

// same-cycle implication, held off during reset
`define LLS_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("scanner assertion failed");

// next-cycle implication, held off during reset
`define LLS_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("scanner assertion failed");

`endif

// File: rtl/core/lls_pkg.sv
// Types, codes and keyword tables of the Lox token scanner
package lls_pkg;

    localparam int OFFSET_BITS = 16;

    typedef logic [OFFSET_BITS-1:0] t_off;

    typedef struct packed {
        logic [7:0] char_byte;
        logic       end_of_input;
    } t_in;

    typedef struct packed {
        logic [5:0]  token_kind;
        logic [15:0] tok_start;
        logic [15:0] tok_length;
        logic [15:0] tok_line;
        logic [1:0]  error_code;
        logic        last;
    } t_out;

    typedef enum logic [11:0] {
        M_IDLE    = 12'b0000_0000_0001,
        M_BANG    = 12'b0000_0000_0010,
        M_EQUAL   = 12'b0000_0000_0100,
        M_GREATER = 12'b0000_0000_1000,
        M_LESS    = 12'b0000_0001_0000,
        M_SLASH   = 12'b0000_0010_0000,
        M_COMMENT = 12'b0000_0100_0000,
        M_STRING  = 12'b0000_1000_0000,
        M_INT     = 12'b0001_0000_0000,
        M_DOT     = 12'b0010_0000_0000,
        M_FRAC    = 12'b0100_0000_0000,
        M_IDENT   = 12'b1000_0000_0000
    } t_mode;

    localparam logic [5:0] K_LPAREN  = 6'd0;
    localparam logic [5:0] K_RPAREN  = 6'd1;
    localparam logic [5:0] K_LBRACE  = 6'd2;
    localparam logic [5:0] K_RBRACE  = 6'd3;
    localparam logic [5:0] K_COMMA   = 6'd4;
    localparam logic [5:0] K_DOT     = 6'd5;
    localparam logic [5:0] K_MINUS   = 6'd6;
    localparam logic [5:0] K_PLUS    = 6'd7;
    localparam logic [5:0] K_SEMI    = 6'd8;
    localparam logic [5:0] K_SLASH   = 6'd9;
    localparam logic [5:0] K_STAR    = 6'd10;
    localparam logic [5:0] K_BANG    = 6'd11;
    localparam logic [5:0] K_BANG_EQ = 6'd12;
    localparam logic [5:0] K_EQ      = 6'd13;
    localparam logic [5:0] K_EQ_EQ   = 6'd14;
    localparam logic [5:0] K_GT      = 6'd15;
    localparam logic [5:0] K_GT_EQ   = 6'd16;
    localparam logic [5:0] K_LT      = 6'd17;
    localparam logic [5:0] K_LT_EQ   = 6'd18;
    localparam logic [5:0] K_IDENT   = 6'd19;
    localparam logic [5:0] K_STRING  = 6'd20;
    localparam logic [5:0] K_NUMBER  = 6'd21;
    localparam logic [5:0] K_KW0     = 6'd22;
    localparam logic [5:0] K_END     = 6'd38;

    localparam logic [1:0] E_NONE   = 2'd0;
    localparam logic [1:0] E_UNEXP  = 2'd1;
    localparam logic [1:0] E_UNTERM = 2'd2;

    localparam logic [47:0] KW_TEXT [16] = '{
        {"and", 24'h0}, {"class", 8'h0}, {"else", 16'h0}, {"false", 8'h0},
        {"fun", 24'h0}, {"for", 24'h0}, {"if", 32'h0}, {"nil", 24'h0},
        {"or", 32'h0}, {"print", 8'h0}, "return", {"super", 8'h0},
        {"this", 16'h0}, {"true", 16'h0}, {"var", 24'h0}, {"while", 8'h0}
    };
    localparam logic [2:0] KW_LEN [16] = '{
        3'd3, 3'd5, 3'd4, 3'd5, 3'd3, 3'd3, 3'd2, 3'd3,
        3'd2, 3'd5, 3'd6, 3'd5, 3'd4, 3'd4, 3'd3, 3'd5
    };

    function automatic logic is_digit(input logic [7:0] c);
        return (c >= "0") && (c <= "9");
    endfunction

    function automatic logic is_alpha(input logic [7:0] c);
        return ((c >= "a") && (c <= "z")) || ((c >= "A") && (c <= "Z")) || (c == "_");
    endfunction

    // byte k of the word sits at [47-8k -: 8]
    function automatic logic [5:0] word_kind(input logic [47:0] w, input logic [2:0] len);
        logic [47:0] mask;
        logic [5:0]  kind;
        mask = ~(48'hFFFF_FFFF_FFFF >> {len, 3'b000});
        kind = K_IDENT;
        for (int i = 0; i < 16; i++) begin
            if ((KW_LEN[i] == len) && (((w ^ KW_TEXT[i]) & mask) == 48'h0)) begin
                kind = 6'(int'(K_KW0) + i);
            end
        end
        return kind;
    endfunction

    // clamped span from s to p, plus an optional extra byte, saturated to 16 bits
    function automatic logic [15:0] span_len(input t_off p, input t_off s, input logic plus1);
        logic [OFFSET_BITS:0] d;
        logic [32:0]          w;
        d = (p >= s) ? {1'b0, p - s} : '0;
        d = d + (OFFSET_BITS+1)'(plus1);
        w = 33'(d);
        return (w > 33'd65535) ? 16'hFFFF : w[15:0];
    endfunction

endpackage

// File: rtl/core/lls_scan.sv
// Scanner state and per-byte transition, producing up to three result words
module lls_scan import lls_pkg::*; (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_step,
    input  t_in             i_in,
    output t_out [2:0]      o_res,
    output logic [1:0]      o_cnt
);

    t_mode       r_mode, n_mode;
    t_off        r_start, n_start;
    t_off        r_pos, n_pos;
    logic [15:0] r_line, n_line;
    logic [47:0] r_word;
    logic [2:0]  r_wlen, n_wlen;

    logic        wr_word;
    logic [2:0]  wr_idx;
    logic [7:0]  c;
    t_off        p, dp;

    // flush of the held token
    t_out        fl_res [2];
    logic [1:0]  fl_n;
    // byte seen from idle
    t_out        id_res;
    logic        id_emit;
    t_mode       id_mode;
    logic        id_nl;
    logic        id_word;

    t_out        tok;
    t_out [2:0]  res;
    logic [1:0]  cnt;
    logic        do_fi, do_id;
    logic [5:0]  eq_kind;

    assign c  = i_in.char_byte;
    assign p  = r_pos;
    assign dp = (r_pos != '0) ? r_pos - t_off'(1) : '0;

    always_comb begin
        tok = '{token_kind: K_LPAREN, tok_start: 16'(r_start), tok_length: 16'd0,
                tok_line: r_line, error_code: E_NONE, last: 1'b0};
        fl_res[0] = tok;
        fl_res[1] = tok;
        fl_n = 2'd1;
        fl_res[0].tok_length = span_len(p, r_start, 1'b0);
        unique case (r_mode)
            M_BANG:    fl_res[0].token_kind = K_BANG;
            M_EQUAL:   fl_res[0].token_kind = K_EQ;
            M_GREATER: fl_res[0].token_kind = K_GT;
            M_LESS:    fl_res[0].token_kind = K_LT;
            M_SLASH:   fl_res[0].token_kind = K_SLASH;
            M_INT, M_FRAC: fl_res[0].token_kind = K_NUMBER;
            M_DOT: begin
                fl_res[0].token_kind = K_NUMBER;
                fl_res[0].tok_length = span_len(dp, r_start, 1'b0);
                fl_res[1].token_kind = K_DOT;
                fl_res[1].tok_start  = 16'(dp);
                fl_res[1].tok_length = 16'd1;
                fl_n = 2'd2;
            end
            M_IDENT:   fl_res[0].token_kind = word_kind(r_word, r_wlen);
            M_STRING:  fl_res[0].error_code = E_UNTERM;
            default:   fl_n = 2'd0;
        endcase
    end

    always_comb begin
        id_res = '{token_kind: K_LPAREN, tok_start: 16'(p), tok_length: 16'd1,
                   tok_line: r_line, error_code: E_NONE, last: 1'b0};
        id_emit = 1'b1;
        id_mode = M_IDLE;
        id_nl   = 1'b0;
        id_word = 1'b0;
        case (c)
            "(": id_res.token_kind = K_LPAREN;
            ")": id_res.token_kind = K_RPAREN;
            "{": id_res.token_kind = K_LBRACE;
            "}": id_res.token_kind = K_RBRACE;
            ",": id_res.token_kind = K_COMMA;
            ".": id_res.token_kind = K_DOT;
            "-": id_res.token_kind = K_MINUS;
            "+": id_res.token_kind = K_PLUS;
            ";": id_res.token_kind = K_SEMI;
            "*": id_res.token_kind = K_STAR;
            "!": begin id_emit = 1'b0; id_mode = M_BANG; end
            "=": begin id_emit = 1'b0; id_mode = M_EQUAL; end
            ">": begin id_emit = 1'b0; id_mode = M_GREATER; end
            "<": begin id_emit = 1'b0; id_mode = M_LESS; end
            "/": begin id_emit = 1'b0; id_mode = M_SLASH; end
            "\"": begin id_emit = 1'b0; id_mode = M_STRING; end
            " ", 8'h0D, 8'h09: id_emit = 1'b0;
            8'h0A: begin id_emit = 1'b0; id_nl = 1'b1; end
            default: begin
                if (is_digit(c)) begin
                    id_emit = 1'b0;
                    id_mode = M_INT;
                end else if (is_alpha(c)) begin
                    id_emit = 1'b0;
                    id_mode = M_IDENT;
                    id_word = 1'b1;
                end else begin
                    id_res.error_code = E_UNEXP;
                end
            end
        endcase
    end

    always_comb begin
        n_mode  = r_mode;
        n_start = r_start;
        n_line  = r_line;
        n_wlen  = r_wlen;
        n_pos   = (r_pos != '1) ? r_pos + t_off'(1) : r_pos;
        wr_word = 1'b0;
        wr_idx  = r_wlen;
        do_fi   = 1'b0;
        do_id   = 1'b0;
        cnt     = 2'd0;
        res     = '{default: tok};
        eq_kind = K_BANG_EQ;
        unique case (r_mode)
            M_EQUAL:   eq_kind = K_EQ_EQ;
            M_GREATER: eq_kind = K_GT_EQ;
            M_LESS:    eq_kind = K_LT_EQ;
            default:   eq_kind = K_BANG_EQ;
        endcase
        if (i_in.end_of_input) begin
            res[0] = fl_res[0];
            res[1] = fl_res[1];
            res[fl_n] = '{token_kind: K_END, tok_start: 16'(p), tok_length: 16'd0,
                          tok_line: r_line, error_code: E_NONE, last: 1'b0};
            cnt     = fl_n + 2'd1;
            n_mode  = M_IDLE;
            n_start = '0;
            n_pos   = '0;
            n_line  = 16'd1;
            n_wlen  = 3'd0;
        end else begin
            unique case (r_mode)
                M_BANG, M_EQUAL, M_GREATER, M_LESS: begin
                    if (c == "=") begin
                        res[0] = tok;
                        res[0].token_kind = eq_kind;
                        res[0].tok_length = span_len(p, r_start, 1'b1);
                        cnt    = 2'd1;
                        n_mode = M_IDLE;
                    end else begin
                        do_fi = 1'b1;
                    end
                end
                M_SLASH: begin
                    if (c == "/") n_mode = M_COMMENT;
                    else do_fi = 1'b1;
                end
                M_COMMENT: begin
                    if (c == "\n") do_id = 1'b1;
                end
                M_STRING: begin
                    if (c == "\"") begin
                        res[0] = tok;
                        res[0].token_kind = K_STRING;
                        res[0].tok_length = span_len(p, r_start, 1'b1);
                        cnt    = 2'd1;
                        n_mode = M_IDLE;
                    end else if ((c == "\n") && (r_line != 16'hFFFF)) begin
                        n_line = r_line + 16'd1;
                    end
                end
                M_INT: begin
                    if (c == ".") n_mode = M_DOT;
                    else if (!is_digit(c)) do_fi = 1'b1;
                end
                M_DOT: begin
                    if (is_digit(c)) n_mode = M_FRAC;
                    else do_fi = 1'b1;
                end
                M_FRAC: begin
                    if (!is_digit(c)) do_fi = 1'b1;
                end
                M_IDENT: begin
                    if (is_alpha(c) || is_digit(c)) begin
                        if (r_wlen < 3'd6) begin
                            wr_word = 1'b1;
                            n_wlen  = r_wlen + 3'd1;
                        end else begin
                            n_wlen  = 3'd7;
                        end
                    end else begin
                        do_fi = 1'b1;
                    end
                end
                default: do_id = 1'b1;
            endcase
            if (do_fi || do_id) begin
                if (do_fi) begin
                    res[0] = fl_res[0];
                    res[1] = fl_res[1];
                    res[fl_n] = id_res;
                    cnt = fl_n + 2'(id_emit);
                end else begin
                    res[0] = id_res;
                    cnt = 2'(id_emit);
                end
                n_start = p;
                n_mode  = id_mode;
                if (id_nl && (r_line != 16'hFFFF)) n_line = r_line + 16'd1;
                if (id_word) begin
                    wr_word = 1'b1;
                    wr_idx  = 3'd0;
                    n_wlen  = 3'd1;
                end
            end
        end
        for (int k = 0; k < 3; k++) begin
            res[k].last = (2'(k + 1) == cnt);
        end
    end

    assign o_res = res;
    assign o_cnt = cnt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode  <= M_IDLE;
            r_start <= '0;
            r_pos   <= '0;
            r_line  <= 16'd1;
            r_wlen  <= 3'd0;
        end else if (i_step) begin
            r_mode  <= n_mode;
            r_start <= n_start;
            r_pos   <= n_pos;
            r_line  <= n_line;
            r_wlen  <= n_wlen;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_step && wr_word && !i_in.end_of_input) begin
            r_word[47 - 8*wr_idx -: 8] <= c;
        end
    end

endmodule

// File: rtl/core/lls_outq.sv
// Result buffer that hands out up to three words per scanned byte
module lls_outq import lls_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_load,
    input  t_out [2:0]  i_res,
    input  logic [1:0]  i_cnt,
    output logic        o_free,
    output logic        o_valid,
    input  logic        i_ready,
    output t_out        o_data
);

    t_out [2:0] r_buf;
    logic [1:0] r_cnt, r_idx;
    logic       take;

    assign o_valid = (r_idx != r_cnt);
    assign take    = o_valid && i_ready;
    assign o_free  = !o_valid || (take && ((r_idx + 2'd1) == r_cnt));
    assign o_data  = r_buf[r_idx];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= 2'd0;
            r_idx <= 2'd0;
        end else if (i_load) begin
            r_cnt <= i_cnt;
            r_idx <= 2'd0;
        end else if (take) begin
            r_idx <= r_idx + 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) r_buf <= i_res;
    end

endmodule

// File: rtl/core/lox_lexer_token_scanner_unit.sv
// Lox token scanner: source bytes in, tokens and errors out as words. Bytes enter
// an input register and are scanned once the result buffer is free; the scan loads
// zero to three result words into a buffer that drains one word per cycle while
// the output is ready. With the output ready, a byte yielding at most one word
// keeps one byte per cycle coming in; a byte yielding more holds the next byte
// until the last word leaves the one output port. No clearing pass follows reset.
module lox_lexer_token_scanner_unit import lls_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    output logic o_in_ready,
    input  t_in  i_in,
    output logic o_out_valid,
    input  logic i_out_ready,
    output t_out o_out
);

    logic       r_in_v;
    t_in        r_in;
    logic       free, step;
    t_out [2:0] res;
    logic [1:0] cnt;

    assign step       = r_in_v && free;
    assign o_in_ready = !r_in_v || step;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_v <= 1'b0;
        end else if (o_in_ready) begin
            r_in_v <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) r_in <= i_in;
    end

    lls_scan u_scan (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_step  (step),
        .i_in    (r_in),
        .o_res   (res),
        .o_cnt   (cnt)
    );

    lls_outq u_outq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (step),
        .i_res   (res),
        .i_cnt   (cnt),
        .o_free  (free),
        .o_valid (o_out_valid),
        .i_ready (i_out_ready),
        .o_data  (o_out)
    );

endmodule

// File: rtl/core/lls_checker.sv
// Port-level checks of the Lox token scanner, bound to the top level
`include "lox_lexer_token_scanner_unit_defines.svh"
module lls_checker import lls_pkg::*; (
    input logic i_clk,
    input logic i_rst_n,
    input logic i_in_valid,
    input logic o_in_ready,
    input t_in  i_in,
    input logic o_out_valid,
    input logic i_out_ready,
    input t_out o_out
);

    `LLS_ASSERT_NEXT(a_out_hold, o_out_valid && !i_out_ready, o_out_valid && $stable(o_out))
    `LLS_ASSERT_NOW(a_end_last, o_out_valid && (o_out.token_kind == K_END), o_out.last)
    `LLS_ASSERT_NOW(a_err_kind, o_out_valid && (o_out.error_code != E_NONE), o_out.token_kind == K_LPAREN)
    `LLS_ASSERT_NOW(a_unexp_len, o_out_valid && (o_out.error_code == E_UNEXP), o_out.tok_length == 16'd1)
    `LLS_ASSERT_NOW(a_line_nz, o_out_valid, o_out.tok_line != 16'd0)

endmodule

bind lox_lexer_token_scanner_unit lls_checker u_chk (.*);
